/* src/line_delimited_rx_fifo_top_defines.svh */
// Assertion macros used by the line receive FIFO datapath.
`ifndef LINE_DELIMITED_RX_FIFO_TOP_DEFINES_SVH
`define LINE_DELIMITED_RX_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LDRX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ldrx assertion failed");

// Next-cycle implication, disabled during reset.
`define LDRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ldrx assertion failed");

`endif

/* src/ldrx_pkg.sv */
`timescale 1ns / 1ps

package ldrx_pkg;

  // Default sizing
  localparam int DEPTH_DEF    = 256;
  localparam int MAX_LINE_DEF = 64;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int MODE_W = 2;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;
  localparam int FILL_W = 9;

  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd10;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_LINE = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  max_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  line_length;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
    logic              is_full;
  } out_item_t;

  // Controller commands to the datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PUSH,
    CMD_CLEAR,
    CMD_POP_RD,
    CMD_POP_EM,
    CMD_SCAN,
    CMD_DECIDE,
    CMD_LINE
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_CLEAR,
    S_POP_RD,
    S_POP_EM,
    S_SCAN,
    S_DECIDE,
    S_LINE
  } state_t;

  // Datapath status to the controller
  typedef struct packed {
    logic empty;
    logic scan_done;
    logic line_go;
    logic line_done;
  } dp_sts_t;

endpackage

/* src/ldrx_ctrl.sv */
`timescale 1ns / 1ps

module ldrx_ctrl import ldrx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  dp_sts_t           sts,
  output logic              busy,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_PUSH:  state_nxt = S_PUSH;
            MODE_POP:   state_nxt = S_POP_RD;
            MODE_CLEAR: state_nxt = S_CLEAR;
            MODE_LINE:  state_nxt = sts.empty ? S_DECIDE : S_SCAN;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH:   state_nxt = S_IDLE;
      S_CLEAR:  state_nxt = S_IDLE;
      S_POP_RD: state_nxt = sts.empty ? S_IDLE : S_POP_EM;
      S_POP_EM: state_nxt = S_IDLE;
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: state_nxt = sts.line_go ? S_LINE : S_IDLE;
      S_LINE: begin
        if (sts.line_done) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (state_r != S_IDLE);
    cmd  = CMD_NONE;
    unique case (state_r)
      S_IDLE:   cmd = start ? CMD_LOAD : CMD_NONE;
      S_PUSH:   cmd = CMD_PUSH;
      S_CLEAR:  cmd = CMD_CLEAR;
      S_POP_RD: cmd = CMD_POP_RD;
      S_POP_EM: cmd = CMD_POP_EM;
      S_SCAN:   cmd = CMD_SCAN;
      S_DECIDE: cmd = CMD_DECIDE;
      S_LINE:   cmd = CMD_LINE;
      default:  cmd = CMD_NONE;
    endcase
  end

endmodule

/* src/ldrx_dp.sv */
`timescale 1ns / 1ps

`include "line_delimited_rx_fifo_top_defines.svh"

module ldrx_dp import ldrx_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int MAX_LINE = MAX_LINE_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int MW = (CW > LEN_W) ? CW : LEN_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  input  in_item_t          in_item,
  input  cmd_t              cmd,
  output dp_sts_t           sts,
  output logic              out_valid,
  output out_item_t         out_item
);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  // Byte store
  logic [BYTE_W-1:0] store_mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [BYTE_W-1:0] mem_wd;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rdata_r;

  // Registers
  logic [BYTE_W-1:0] delim_r;
  in_item_t          item_r, item_nxt;
  logic [AW-1:0]     wr_r, wr_nxt;
  logic [AW-1:0]     rd_r, rd_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic [AW-1:0]     scan_addr_r, scan_addr_nxt;
  logic [CW-1:0]     issued_r, issued_nxt;
  logic [CW-1:0]     seen_r, seen_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     dist_r, dist_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [LEN_W-1:0]  iss_n_r, iss_n_nxt;
  logic [LEN_W-1:0]  emit_n_r, emit_n_nxt;
  logic              emv_r, emv_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // Scan and line-decision terms
  logic              hit;
  logic              last_cmp;
  logic [LEN_W-1:0]  lim_raw;
  logic [LEN_W-1:0]  lim;
  logic [CW-1:0]     avail;
  logic [MW-1:0]     n_w;
  logic              fail;
  logic              line_last;

  // Emission fields
  logic              emit;
  logic [BYTE_W-1:0] o_byte;
  logic              o_last;
  logic [STAT_W-1:0] o_status;
  logic [LEN_W-1:0]  o_len;

  assign hit       = cmp_v_r && (rdata_r == delim_r);
  assign last_cmp  = cmp_v_r && ((seen_r + CW'(1)) == held_r);
  assign lim_raw   = (item_r.max_length != '0) ? item_r.max_length - LEN_W'(1) : '0;
  assign lim       = (lim_raw > LEN_W'(MAX_LINE)) ? LEN_W'(MAX_LINE) : lim_raw;
  assign avail     = found_r ? dist_r : held_r;
  assign n_w       = (MW'(lim) < MW'(avail)) ? MW'(lim) : MW'(avail);
  assign fail      = (held_r == '0) || (!found_r && (held_r != CW'(DEPTH)));
  assign line_last = emv_r && ((emit_n_r + LEN_W'(1)) == n_r);

  assign sts.empty     = (held_r == '0);
  assign sts.scan_done = hit || last_cmp;
  assign sts.line_go   = !fail && (lim != '0);
  assign sts.line_done = line_last;

  // Next-value logic per command
  always_comb begin
    item_nxt      = item_r;
    wr_nxt        = wr_r;
    rd_nxt        = rd_r;
    held_nxt      = held_r;
    scan_addr_nxt = scan_addr_r;
    issued_nxt    = issued_r;
    seen_nxt      = seen_r;
    cmp_v_nxt     = cmp_v_r;
    found_nxt     = found_r;
    dist_nxt      = dist_r;
    n_nxt         = n_r;
    iss_n_nxt     = iss_n_r;
    emit_n_nxt    = emit_n_r;
    emv_nxt       = emv_r;
    mem_we        = 1'b0;
    mem_wa        = wr_r;
    mem_wd        = item_r.data_byte;
    rd_en         = 1'b0;
    rd_addr       = rd_r;
    emit          = 1'b0;
    o_byte        = '0;
    o_last        = 1'b1;
    o_status      = ST_OK;
    o_len         = '0;

    unique case (cmd)
      CMD_LOAD: begin
        item_nxt      = in_item;
        scan_addr_nxt = rd_r;
        issued_nxt    = '0;
        seen_nxt      = '0;
        cmp_v_nxt     = 1'b0;
        found_nxt     = 1'b0;
        dist_nxt      = '0;
      end
      CMD_PUSH: begin
        emit = 1'b1;
        if (held_r < CW'(DEPTH)) begin
          mem_we   = 1'b1;
          wr_nxt   = next_slot(wr_r);
          held_nxt = held_r + CW'(1);
        end else begin
          o_status = ST_DROPPED;
        end
      end
      CMD_CLEAR: begin
        emit     = 1'b1;
        wr_nxt   = '0;
        rd_nxt   = '0;
        held_nxt = '0;
      end
      CMD_POP_RD: begin
        if (held_r != '0) begin
          rd_en    = 1'b1;
          rd_nxt   = next_slot(rd_r);
          held_nxt = held_r - CW'(1);
        end else begin
          emit = 1'b1;
        end
      end
      CMD_POP_EM: begin
        emit   = 1'b1;
        o_byte = rdata_r;
      end
      CMD_SCAN: begin
        // read one slot ahead, compare the slot read last cycle
        if (issued_r < held_r) begin
          rd_en         = 1'b1;
          rd_addr       = scan_addr_r;
          scan_addr_nxt = next_slot(scan_addr_r);
          issued_nxt    = issued_r + CW'(1);
          cmp_v_nxt     = 1'b1;
        end else begin
          cmp_v_nxt = 1'b0;
        end
        if (cmp_v_r) begin
          seen_nxt = seen_r + CW'(1);
          if (hit) begin
            found_nxt = 1'b1;
            dist_nxt  = seen_r + CW'(1);
          end
        end
      end
      CMD_DECIDE: begin
        if (fail) begin
          emit     = 1'b1;
          o_status = ST_NO_LINE;
        end else if (lim == '0) begin
          emit = 1'b1;
        end else begin
          n_nxt      = LEN_W'(n_w);
          held_nxt   = held_r - CW'(n_w);
          iss_n_nxt  = '0;
          emit_n_nxt = '0;
          emv_nxt    = 1'b0;
        end
      end
      CMD_LINE: begin
        // pop pipeline: issue a read, emit its byte next cycle
        if (iss_n_r < n_r) begin
          rd_en     = 1'b1;
          rd_nxt    = next_slot(rd_r);
          iss_n_nxt = iss_n_r + LEN_W'(1);
          emv_nxt   = 1'b1;
        end else begin
          emv_nxt = 1'b0;
        end
        if (emv_r) begin
          emit       = 1'b1;
          emit_n_nxt = emit_n_r + LEN_W'(1);
          o_byte     = rdata_r;
          o_last     = line_last;
          o_len      = line_last ? n_r : '0;
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt          = emit;
    out_nxt.out_byte       = o_byte;
    out_nxt.last           = o_last;
    out_nxt.status         = o_status;
    out_nxt.line_length    = o_len;
    out_nxt.fill_count     = FILL_W'(held_nxt);
    out_nxt.is_empty       = (held_nxt == '0);
    out_nxt.is_full        = (held_nxt == CW'(DEPTH));
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_wa] <= mem_wd;
    if (rd_en) rdata_r <= store_mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= DELIM_RESET;
      wr_r        <= '0;
      rd_r        <= '0;
      held_r      <= '0;
      cmp_v_r     <= 1'b0;
      emv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) delim_r <= cfg_wr_data;
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      held_r      <= held_nxt;
      cmp_v_r     <= cmp_v_nxt;
      emv_r       <= emv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    scan_addr_r <= scan_addr_nxt;
    issued_r    <= issued_nxt;
    seen_r      <= seen_nxt;
    found_r     <= found_nxt;
    dist_r      <= dist_nxt;
    n_r         <= n_nxt;
    iss_n_r     <= iss_n_nxt;
    emit_n_r    <= emit_n_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  `LDRX_ASSERT_IMPL(a_held_range, clk, rst_n, 1'b1, held_r <= CW'(DEPTH))
  `LDRX_ASSERT_IMPL(a_mid_line_ok, clk, rst_n, out_valid_r && !out_r.last, out_r.status == ST_OK)
  `LDRX_ASSERT_IMPL(a_len_on_last, clk, rst_n, out_valid_r && (out_r.line_length != '0), out_r.last)
  `LDRX_ASSERT_IMPL(a_drop_full, clk, rst_n, out_valid_r && (out_r.status == ST_DROPPED), out_r.is_full)

endmodule

/* src/line_delimited_rx_fifo_top.sv */
`timescale 1ns / 1ps

// Channel   Ports                        Handshake
// input     in_item (mode, byte, max)    start high while busy low
// result    out_item                     out_valid strobe, one cycle each
// config    cfg_wr_en, cfg_wr_data       written on any edge with cfg_wr_en, out of reset
//
// Push, pop, clear: load, then a result state; a held-byte pop reads, then emits.
// Read line: a scan up to the first delimiter (at most fill_count stored bytes)
//   at one byte per cycle through the single registered memory read port, a
//   decision state, then one result per popped byte, or a single result when
//   no line is popped. An empty buffer skips the scan.
// Synchronous active-low reset empties the buffer and sets the delimiter to 10.
// Results cannot be stalled; busy drops once the final result is registered.

module line_delimited_rx_fifo_top import ldrx_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data
);

  cmd_t    cmd;
  dp_sts_t sts;

  ldrx_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  ldrx_dp #(
    .DEPTH    (DEPTH),
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule

/* tb/ldrx_checker.sv */
`timescale 1ns / 1ps

// Watches the command and result channels of the line receive FIFO, keeps its
// own copy of the ring buffer and compares every result beat in order.
module ldrx_checker import ldrx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  out_item_t         out_item,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  output int                mismatch_count,
  output int                pending_beats
);

  // Shadow copy of the buffer state
  logic [BYTE_W-1:0] ring [DEPTH_DEF];
  logic [7:0]        wr_ptr;
  logic [7:0]        rd_ptr;
  logic [FILL_W-1:0] held;
  logic [BYTE_W-1:0] delim;

  out_item_t expected_beats[$];

  initial begin
    mismatch_count = 0;
    pending_beats  = 0;
  end

  function automatic logic [BYTE_W-1:0] take_oldest();
    logic [BYTE_W-1:0] b;
    b = '0;
    if (held != 0) begin
      b      = ring[rd_ptr];
      rd_ptr = rd_ptr + 8'd1;
      held   = held - 1'b1;
    end
    return b;
  endfunction

  function automatic bit line_present();
    logic [7:0] p;
    p = rd_ptr;
    for (int n = 0; n < held; n++) begin
      if (ring[p] == delim) return 1'b1;
      p = p + 8'd1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t make_beat(logic [BYTE_W-1:0] b, logic lst,
                                          logic [STAT_W-1:0] st, logic [LEN_W-1:0] len);
    out_item_t r;
    r             = '0;
    r.out_byte    = b;
    r.last        = lst;
    r.status      = st;
    r.line_length = len;
    return r;
  endfunction

  // Work out every result beat caused by one accepted command
  task automatic line_fifo_predict(in_item_t it);
    out_item_t beats[$];
    int        limit;
    int        n;
    logic [BYTE_W-1:0] b;
    case (it.mode)
      MODE_PUSH: begin
        if (held < DEPTH_DEF) begin
          ring[wr_ptr] = it.data_byte;
          wr_ptr       = wr_ptr + 8'd1;
          held         = held + 1'b1;
          beats.push_back(make_beat('0, 1'b1, ST_OK, '0));
        end else begin
          beats.push_back(make_beat('0, 1'b1, ST_DROPPED, '0));
        end
      end
      MODE_POP: begin
        b = take_oldest();
        beats.push_back(make_beat(b, 1'b1, ST_OK, '0));
      end
      MODE_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        held   = '0;
        beats.push_back(make_beat('0, 1'b1, ST_OK, '0));
      end
      default: begin
        if (held == 0 || (!line_present() && held != DEPTH_DEF)) begin
          beats.push_back(make_beat('0, 1'b1, ST_NO_LINE, '0));
        end else begin
          limit = (it.max_length > 0) ? int'(it.max_length) - 1 : 0;
          if (limit > MAX_LINE_DEF) limit = MAX_LINE_DEF;
          if (limit == 0) begin
            beats.push_back(make_beat('0, 1'b1, ST_OK, '0));
          end else begin
            n = 0;
            while (n < limit && held != 0) begin
              b = take_oldest();
              beats.push_back(make_beat(b, 1'b0, ST_OK, '0));
              n++;
              if (b == delim) break;
            end
            beats[n-1].last        = 1'b1;
            beats[n-1].line_length = LEN_W'(n);
          end
        end
      end
    endcase
    // occupancy fields reflect the state after the whole command
    foreach (beats[k]) begin
      beats[k].fill_count = held;
      beats[k].is_empty   = (held == 0);
      beats[k].is_full    = (held == DEPTH_DEF);
      expected_beats.push_back(beats[k]);
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      wr_ptr = '0;
      rd_ptr = '0;
      held   = '0;
      delim  = DELIM_RESET;
      expected_beats.delete();
    end else begin
      // result beat first: it always belongs to an earlier command
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %p", $time, out_item);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("out_byte", want.out_byte, out_item.out_byte);
          check_field("last", want.last, out_item.last);
          check_field("status", want.status, out_item.status);
          check_field("line_length", want.line_length, out_item.line_length);
          check_field("fill_count", want.fill_count, out_item.fill_count);
          check_field("is_empty", want.is_empty, out_item.is_empty);
          check_field("is_full", want.is_full, out_item.is_full);
        end
      end
      if (cfg_wr_en) delim = cfg_wr_data;
      if (start && !busy) line_fifo_predict(in_item);
    end
    pending_beats = expected_beats.size();
  end

endmodule

/* tb/line_delimited_rx_fifo_top_tb.sv */
`timescale 1ns / 1ps

module line_delimited_rx_fifo_top_tb;
  import ldrx_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_wr_en = 1'b0;
  logic [BYTE_W-1:0] cfg_wr_data = '0;

  int                mismatch_count;
  int                pending_beats;
  int                cmds_sent = 0;
  int                idle_cycles = 0;
  bit                no_gaps = 1'b0;
  logic [BYTE_W-1:0] cur_delim = DELIM_RESET;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  line_delimited_rx_fifo_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ldrx_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .pending_beats  (pending_beats)
  );

  // Watchdog: cycles with neither a command nor a result beat accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("line_delimited_rx_fifo_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one command beat and hold it until accepted
  task automatic send(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
                      logic [LEN_W-1:0] max_len);
    int gap;
    in_item.mode       <= mode;
    in_item.data_byte  <= data;
    in_item.max_length <= max_len;
    start              <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    cmds_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start              <= 1'b0;
      in_item.data_byte  <= BYTE_W'($urandom);
      in_item.max_length <= LEN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every expected beat is back and the block is free
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_delim(logic [BYTE_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cur_delim    = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == cur_delim);
    return b;
  endfunction

  function automatic logic [LEN_W-1:0] pick_max_len();
    if ($urandom_range(0, 9) < 8) return LEN_W'($urandom_range(2, 65));
    return LEN_W'($urandom);
  endfunction

  // Any of the four modes
  function automatic logic [MODE_W-1:0] pick_any_mode();
    return MODE_W'($urandom);
  endfunction

  // Buffer overflow, read line on a full buffer, pointer wrap
  task automatic flood_run();
    send(MODE_CLEAR, '0, '0);
    repeat (DEPTH_DEF + 1) send(MODE_PUSH, plain_byte(), '0);
    send(MODE_LINE, '0, 7'd127);
    send(MODE_PUSH, plain_byte(), '0);
    repeat (64) send(MODE_PUSH, plain_byte(), '0);
    send(MODE_LINE, '0, 7'd20);
    send(MODE_POP, '0, '0);
    repeat (5) send(MODE_PUSH, plain_byte(), '0);
    send(MODE_PUSH, cur_delim, '0);
    repeat (3) send(MODE_LINE, '0, 7'd65);
    send(MODE_CLEAR, '0, '0);
  endtask

  // Random traffic: mostly complete lines, plus pops, clears and noise
  task automatic random_run(int count);
    int stop_at;
    int sel;
    int n;
    stop_at = cmds_sent + count;
    while (cmds_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        n = $urandom_range(0, 24);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send(MODE_PUSH, BYTE_W'($urandom), '0);
          else send(MODE_PUSH, plain_byte(), '0);
        end
        if ($urandom_range(0, 99) < 85) send(MODE_PUSH, cur_delim, '0);
        send(MODE_LINE, BYTE_W'($urandom), pick_max_len());
      end else if (sel < 70) begin
        send(MODE_LINE, BYTE_W'($urandom), pick_max_len());
      end else if (sel < 82) begin
        repeat ($urandom_range(1, 4)) send(MODE_POP, BYTE_W'($urandom), LEN_W'($urandom));
      end else if (sel < 94) begin
        send(pick_any_mode(), BYTE_W'($urandom), LEN_W'($urandom));
      end else begin
        send(MODE_CLEAR, BYTE_W'($urandom), LEN_W'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty buffer, field extremes, short limits, delimiter at slot 0
    send(MODE_POP, '0, '0);
    send(MODE_LINE, '0, 7'd65);
    send(MODE_CLEAR, '0, '0);
    send(MODE_PUSH, 8'h00, '0);
    send(MODE_PUSH, 8'hFF, '0);
    send(MODE_LINE, '0, 7'd65);
    send(MODE_PUSH, DELIM_RESET, '0);
    send(MODE_LINE, '0, 7'd0);
    send(MODE_LINE, '0, 7'd1);
    send(MODE_LINE, '0, 7'd2);
    send(MODE_LINE, '0, 7'd127);
    send(MODE_CLEAR, '0, '0);
    send(MODE_PUSH, DELIM_RESET, '0);
    send(MODE_LINE, '0, 7'd65);
    send(MODE_PUSH, 8'h55, '0);
    send(MODE_PUSH, 8'hAA, '0);
    send(MODE_PUSH, 8'h33, '0);
    send(MODE_CLEAR, '0, '0);
    send(MODE_POP, '0, '0);
    send(MODE_PUSH, 8'h55, '0);
    send(MODE_PUSH, 8'hAA, '0);
    send(MODE_POP, '0, '0);
    send(MODE_POP, '0, '0);
    send(MODE_POP, '0, '0);

    set_delim(8'd0);
    random_run(5);
    set_delim(8'd255);
    flood_run();
    random_run(5);
    set_delim(BYTE_W'($urandom_range(1, 254)));
    random_run(5);
    set_delim(DELIM_RESET);
    random_run(5);

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("line_delimited_rx_fifo_top test passed");
    end else begin
      $display("line_delimited_rx_fifo_top test failed");
    end
    $finish;
  end

endmodule
